// ===== hdl/vertex_rotate_project_defines.svh =====
// ----------------------------------------------------------------------------
// vertex_rotate_project_defines.svh
// Assertion macros shared by the vertex rotate/project RTL.
// ----------------------------------------------------------------------------
`ifndef VERTEX_ROTATE_PROJECT_DEFINES_SVH
`define VERTEX_ROTATE_PROJECT_DEFINES_SVH

`ifndef ASSERT_OFF
// checked outside reset
`define VRP_ASSERT(name, prop) \
   name: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("vertex_rotate_project: assertion failed");
// checked in every cycle, reset included
`define VRP_ASSERT_ALWAYS(name, prop) \
   name: assert property (@(posedge clock) prop) \
      else $error("vertex_rotate_project: assertion failed");
`else
`define VRP_ASSERT(name, prop)
`define VRP_ASSERT_ALWAYS(name, prop)
`endif

`endif

// ===== hdl/vrp_pkg.sv =====
// ----------------------------------------------------------------------------
// vrp_pkg
// Types and constants of the vertex rotate/project pipeline.
// ----------------------------------------------------------------------------
package vrp_pkg;

   localparam int COORD_W   = 16;
   localparam int CFG_W     = 16;
   localparam int CSR_IDX_W = 8;
   localparam int SCR_W     = 12;
   localparam int PROD_W    = 32;
   localparam int SUM_W     = 33;
   localparam int WIDE_W    = 49;
   localparam int ROT_W     = 52;
   localparam int NUM_W     = 64;
   localparam int FRAC_SH   = 14;
   localparam int DIV_STEPS = 12;
   localparam int ROT_STAGES  = 4;
   localparam int PREP_STAGES = 3;
   localparam int PIPE_DEPTH  = ROT_STAGES + PREP_STAGES + DIV_STEPS;

   // viewer distance 160 and centre term 120*160, both at Q.36
   localparam logic signed [NUM_W-1:0] VIEW_OFF   = 64'sd160 <<< 36;
   localparam logic signed [NUM_W-1:0] CENTER_OFF = 64'sd19200 <<< 36;

   localparam logic signed [SCR_W-1:0] SCR_MAX = 12'sd2047;
   localparam logic signed [SCR_W-1:0] SCR_MIN = -12'sd2048;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_COS_PITCH = 8'd0,
      REG_SIN_PITCH = 8'd1,
      REG_COS_YAW   = 8'd2,
      REG_SIN_YAW   = 8'd3
   } csr_index_type;

   typedef struct packed {
      logic [CFG_W-1:0] cos_pitch;
      logic [CFG_W-1:0] sin_pitch;
      logic [CFG_W-1:0] cos_yaw;
      logic [CFG_W-1:0] sin_yaw;
   } rot_cfg_type;

endpackage

// ===== hdl/vrp_rotate.sv =====
// ----------------------------------------------------------------------------
// vrp_rotate
// Four-stage rotation about X then Y, full product precision (Q.36 out).
// ----------------------------------------------------------------------------
module vrp_rotate (
   input  logic                                  clock,
   input  vrp_pkg::rot_cfg_type                  cfg,
   input  logic signed [vrp_pkg::COORD_W-1:0]    vx,
   input  logic signed [vrp_pkg::COORD_W-1:0]    vy,
   input  logic signed [vrp_pkg::COORD_W-1:0]    vz,
   output logic signed [vrp_pkg::ROT_W-1:0]      nx,
   output logic signed [vrp_pkg::ROT_W-1:0]      ny,
   output logic signed [vrp_pkg::ROT_W-1:0]      nz
);
   import vrp_pkg::*;

   logic signed [CFG_W-1:0] cp, sp, cy, sy;
   logic signed [PROD_W-1:0] pyc_ff, pzs_ff, pys_ff, pzc_ff, pxc_ff, pxs_ff;
   logic signed [SUM_W-1:0] ny22_ff, nz22_ff;
   logic signed [PROD_W-1:0] xc2_ff, xs2_ff, xc3_ff, xs3_ff;
   logic signed [SUM_W-1:0] ny3_ff;
   logic signed [WIDE_W-1:0] nzs_ff, nzc_ff;
   logic signed [ROT_W-1:0] nx_ff, ny_ff, nz_ff;
   logic signed [ROT_W-1:0] nx_in, ny_in, nz_in;

   assign cp = $signed(cfg.cos_pitch);
   assign sp = $signed(cfg.sin_pitch);
   assign cy = $signed(cfg.cos_yaw);
   assign sy = $signed(cfg.sin_yaw);

   always_comb begin
      nx_in = (ROT_W'(xc3_ff) <<< FRAC_SH) - ROT_W'(nzs_ff);
      nz_in = (ROT_W'(xs3_ff) <<< FRAC_SH) + ROT_W'(nzc_ff);
      ny_in = ROT_W'(ny3_ff) <<< FRAC_SH;
   end

   always_ff @(posedge clock) begin
      // stage 1: all products with the input vertex
      pyc_ff <= vy * cp;
      pzs_ff <= vz * sp;
      pys_ff <= vy * sp;
      pzc_ff <= vz * cp;
      pxc_ff <= vx * cy;
      pxs_ff <= vx * sy;
      // stage 2: pitch rotation
      ny22_ff <= SUM_W'(pyc_ff) - SUM_W'(pzs_ff);
      nz22_ff <= SUM_W'(pys_ff) + SUM_W'(pzc_ff);
      xc2_ff  <= pxc_ff;
      xs2_ff  <= pxs_ff;
      // stage 3: yaw products on rotated z
      nzs_ff <= WIDE_W'(nz22_ff) * WIDE_W'(sy);
      nzc_ff <= WIDE_W'(nz22_ff) * WIDE_W'(cy);
      ny3_ff <= ny22_ff;
      xc3_ff <= xc2_ff;
      xs3_ff <= xs2_ff;
      // stage 4: yaw sums
      nx_ff <= nx_in;
      ny_ff <= ny_in;
      nz_ff <= nz_in;
   end

   assign nx = nx_ff;
   assign ny = ny_ff;
   assign nz = nz_ff;

endmodule

// ===== hdl/vrp_divider.sv =====
// ----------------------------------------------------------------------------
// vrp_divider
// Pipelined restoring divider, one quotient bit per stage, 12 stages.
// ----------------------------------------------------------------------------
module vrp_divider (
   input  logic                              clock,
   input  logic [vrp_pkg::NUM_W-1:0]         num,
   input  logic [vrp_pkg::NUM_W-1:0]         den,
   output logic [vrp_pkg::DIV_STEPS-1:0]     quo
);
   import vrp_pkg::*;

   logic [NUM_W-1:0]     rem_ff [DIV_STEPS];
   logic [NUM_W-1:0]     den_ff [DIV_STEPS];
   logic [DIV_STEPS-1:0] quo_ff [DIV_STEPS];
   logic [NUM_W-1:0]     rem_src [DIV_STEPS];
   logic [NUM_W-1:0]     den_src [DIV_STEPS];
   logic [DIV_STEPS-1:0] quo_src [DIV_STEPS];
   logic [NUM_W-1:0]     rem_in [DIV_STEPS];
   logic [DIV_STEPS-1:0] quo_in [DIV_STEPS];

   always_comb begin
      for (int j = 0; j < DIV_STEPS; j++) begin
         if (j == 0) begin
            rem_src[j] = num;
            den_src[j] = den;
            quo_src[j] = '0;
         end else begin
            rem_src[j] = rem_ff[j-1];
            den_src[j] = den_ff[j-1];
            quo_src[j] = quo_ff[j-1];
         end
         // stage j decides quotient bit DIV_STEPS-1-j
         if (rem_src[j] >= (den_src[j] << (DIV_STEPS - 1 - j))) begin
            rem_in[j] = rem_src[j] - (den_src[j] << (DIV_STEPS - 1 - j));
            quo_in[j] = quo_src[j] | (DIV_STEPS'(1) << (DIV_STEPS - 1 - j));
         end else begin
            rem_in[j] = rem_src[j];
            quo_in[j] = quo_src[j];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < DIV_STEPS; j++) begin
         rem_ff[j] <= rem_in[j];
         den_ff[j] <= den_src[j];
         quo_ff[j] <= quo_in[j];
      end
   end

   assign quo = quo_ff[DIV_STEPS-1];

endmodule

// ===== hdl/vertex_rotate_project.sv =====
// ----------------------------------------------------------------------------
// vertex_rotate_project
// Rotates a Q7.8 vertex about X then Y and projects it with perspective.
// ----------------------------------------------------------------------------
// One vertex is taken in every cycle (busy stays low) and its result appears
// on rsp_* with rsp_valid high for one cycle; results cannot be held off, so
// the consumer must take every strobe. The depth is set by four rotation
// stages, three projection set-up stages, twelve divider stages (one
// quotient bit each) and the output register. Write the cos/sin registers
// only when no vertex is in flight.
module vertex_rotate_project (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic signed [vrp_pkg::COORD_W-1:0]    req_vx,
   input  logic signed [vrp_pkg::COORD_W-1:0]    req_vy,
   input  logic signed [vrp_pkg::COORD_W-1:0]    req_vz,
   output logic                                  rsp_valid,
   output logic signed [vrp_pkg::SCR_W-1:0]      rsp_screen_x,
   output logic signed [vrp_pkg::SCR_W-1:0]      rsp_screen_y,
   output logic                                  rsp_behind_viewer,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [vrp_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [vrp_pkg::CFG_W-1:0]             csr_wdata
);
   import vrp_pkg::*;
   `include "vertex_rotate_project_defines.svh"

   rot_cfg_type cfg_ff;
   logic [PIPE_DEPTH-1:0] vld_ff;
   logic signed [ROT_W-1:0] nx, ny, nz;
   logic signed [NUM_W-1:0] nx64, ny64, nz64;
   logic signed [NUM_W-1:0] d5_ff, tnx_ff, tny_ff, tc_ff;
   logic signed [NUM_W-1:0] d6_ff, tx_ff, ty_ff;
   logic [NUM_W-1:0] d7_ff, ax_ff, ay_ff;
   logic negx7_ff, negy7_ff, beh7_ff;
   logic [DIV_STEPS-1:0] negx_ff, negy_ff, beh_ff;
   logic [DIV_STEPS-1:0] qx, qy;
   logic rsp_valid_ff, rsp_beh_ff;
   logic signed [SCR_W-1:0] rsp_x_ff, rsp_y_ff, rsp_x_in, rsp_y_in;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.cos_pitch <= CFG_W'(16384);
         cfg_ff.sin_pitch <= '0;
         cfg_ff.cos_yaw   <= CFG_W'(16384);
         cfg_ff.sin_yaw   <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_COS_PITCH: cfg_ff.cos_pitch <= csr_wdata;
            REG_SIN_PITCH: cfg_ff.sin_pitch <= csr_wdata;
            REG_COS_YAW:   cfg_ff.cos_yaw   <= csr_wdata;
            REG_SIN_YAW:   cfg_ff.sin_yaw   <= csr_wdata;
            default: ;
         endcase
      end
   end

   vrp_rotate u_rotate (
      .clock (clock),
      .cfg   (cfg_ff),
      .vx    (req_vx),
      .vy    (req_vy),
      .vz    (req_vz),
      .nx    (nx),
      .ny    (ny),
      .nz    (nz)
   );

   assign nx64 = NUM_W'(nx);
   assign ny64 = NUM_W'(ny);
   assign nz64 = NUM_W'(nz);

   always_ff @(posedge clock) begin
      // 240*n and 120*D as shift-and-add
      d5_ff  <= nz64 + VIEW_OFF;
      tnx_ff <= (nx64 <<< 8) - (nx64 <<< 4);
      tny_ff <= (ny64 <<< 8) - (ny64 <<< 4);
      tc_ff  <= (nz64 <<< 7) - (nz64 <<< 3) + CENTER_OFF;
      d6_ff <= d5_ff;
      tx_ff <= tnx_ff + tc_ff;
      ty_ff <= tny_ff + tc_ff;
      // magnitudes for the unsigned divider
      d7_ff    <= d6_ff;
      beh7_ff  <= (d6_ff <= 0);
      negx7_ff <= tx_ff[NUM_W-1];
      negy7_ff <= ty_ff[NUM_W-1];
      ax_ff    <= tx_ff[NUM_W-1] ? NUM_W'(-tx_ff) : tx_ff;
      ay_ff    <= ty_ff[NUM_W-1] ? NUM_W'(-ty_ff) : ty_ff;
      negx_ff <= {negx_ff[DIV_STEPS-2:0], negx7_ff};
      negy_ff <= {negy_ff[DIV_STEPS-2:0], negy7_ff};
      beh_ff  <= {beh_ff[DIV_STEPS-2:0], beh7_ff};
   end

   vrp_divider u_div_x (
      .clock (clock),
      .num   (ax_ff),
      .den   (d7_ff),
      .quo   (qx)
   );

   vrp_divider u_div_y (
      .clock (clock),
      .num   (ay_ff),
      .den   (d7_ff),
      .quo   (qy)
   );

   // top quotient bit means magnitude of at least 2048: saturate
   always_comb begin
      if (qx[DIV_STEPS-1]) begin
         rsp_x_in = negx_ff[DIV_STEPS-1] ? SCR_MIN : SCR_MAX;
      end else begin
         rsp_x_in = negx_ff[DIV_STEPS-1] ? -$signed(qx) : $signed(qx);
      end
      if (qy[DIV_STEPS-1]) begin
         rsp_y_in = negy_ff[DIV_STEPS-1] ? SCR_MIN : SCR_MAX;
      end else begin
         rsp_y_in = negy_ff[DIV_STEPS-1] ? -$signed(qy) : $signed(qy);
      end
      if (beh_ff[DIV_STEPS-1]) begin
         rsp_x_in = '0;
         rsp_y_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         vld_ff       <= {vld_ff[PIPE_DEPTH-2:0], start && !busy};
         rsp_valid_ff <= vld_ff[PIPE_DEPTH-1];
      end
      rsp_x_ff   <= rsp_x_in;
      rsp_y_ff   <= rsp_y_in;
      rsp_beh_ff <= beh_ff[DIV_STEPS-1];
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_screen_x      = rsp_x_ff;
   assign rsp_screen_y      = rsp_y_ff;
   assign rsp_behind_viewer = rsp_beh_ff;

   `VRP_ASSERT(a_behind_zero, rsp_valid && rsp_behind_viewer |-> rsp_screen_x == 0 && rsp_screen_y == 0)
   `VRP_ASSERT(a_rsp_from_item, rsp_valid |-> $past(start && !busy, PIPE_DEPTH + 1))
   `VRP_ASSERT_ALWAYS(a_reset_quiet, reset |=> !rsp_valid)

endmodule
